// File: src/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg: shared types and constants of the dual stepper sequencer
// Item layouts, command and state codes, coil patterns and rate constants.
// ----------------------------------------------------------------------------
package dss_pkg;

    // Timer and rate constants
    localparam int unsigned PRESCALE       = 8;
    localparam int unsigned RATE_DEFAULT   = 100;
    localparam int unsigned RATE_MAX       = 20000;
    localparam int unsigned RATE_MED       = 77;
    localparam int unsigned RATE_LOW       = 10;
    localparam int unsigned ONE_KHZ        = 1000;
    localparam int unsigned ZERO_RATE_REPS = 2000;
    localparam int unsigned PERIOD_MAX     = 65535;

    localparam int unsigned LIMIT_W    = 11;
    localparam int unsigned PERIOD_W   = 16;
    localparam int unsigned RATE_W     = 15;
    localparam int unsigned COUNT_W    = 32;

    // Command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = 1;
    localparam int unsigned QCNT_W      = 2;

    // Configuration register indexes
    localparam logic CFG_STEP_RATE  = 1'b0;
    localparam logic CFG_DRIVE_MODE = 1'b1;

    // Drive modes
    localparam logic [1:0] MODE_FULL = 2'd0;
    localparam logic [1:0] MODE_WAVE = 2'd1;
    localparam logic [1:0] MODE_HALF = 2'd2;

    localparam logic [3:0]         PINS_IDLE = 4'hA;
    localparam logic [COUNT_W-1:0] COUNT_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_INIT,
        OP_SET_STEPS,
        OP_START,
        OP_SET_START,
        OP_STOP,
        OP_END,
        OP_QUERY
    } op_t;

    typedef enum logic [1:0] {
        RUN_OFF,
        RUN_INITED,
        RUN_STEPPING,
        RUN_HALTED
    } run_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_SHIFT,
        DIV_FINISH
    } div_state_t;

    typedef struct packed {
        op_t                 op;
        logic                channel;
        logic                move_direction;
        logic signed [31:0]  step_total;
    } in_item_t;

    typedef struct packed {
        logic                status;
        logic [3:0]          coils_first;
        logic                enable_first;
        logic [3:0]          coils_second;
        logic                enable_second;
        logic signed [31:0]  remaining;
        logic                is_stepping;
        logic                current_direction;
        logic [15:0]         timer_period;
        logic                timer_on;
    } out_item_t;

    // Configuration write as seen inside the block (handshake already complete)
    typedef struct packed {
        logic              valid;
        logic              index;
        logic [RATE_W-1:0] data;
    } cfg_wr_t;

    // Classified command handed from front to back
    typedef struct packed {
        op_t                op;
        logic               channel;
        logic               dir;
        logic [COUNT_W-1:0] steps;
        logic               steps_zero;
    } cmd_t;

    // New pacing values from the rate unit
    typedef struct packed {
        logic                valid;
        logic [LIMIT_W-1:0]  limit;
        logic [PERIOD_W-1:0] period;
    } rate_upd_t;

    // Per-channel motor state
    typedef struct packed {
        run_state_t         st;
        logic [2:0]         phase;
        logic               dir;
        logic [COUNT_W-1:0] count;
        logic [3:0]         pins;
        logic               en;
    } chan_t;

    function automatic logic [3:0] full_pattern(input logic [1:0] idx);
        logic [3:0] p;
        case (idx)
            2'd0:    p = 4'hA;
            2'd1:    p = 4'h9;
            2'd2:    p = 4'h5;
            default: p = 4'h6;
        endcase
        return p;
    endfunction

    function automatic logic [3:0] wave_pattern(input logic [1:0] idx);
        logic [3:0] p;
        case (idx)
            2'd0:    p = 4'h8;
            2'd1:    p = 4'h2;
            2'd2:    p = 4'h4;
            default: p = 4'h1;
        endcase
        return p;
    endfunction

    function automatic logic [3:0] half_pattern(input logic [2:0] idx);
        logic [3:0] p;
        case (idx)
            3'd0:    p = 4'h8;
            3'd1:    p = 4'hA;
            3'd2:    p = 4'h2;
            3'd3:    p = 4'h6;
            3'd4:    p = 4'h4;
            3'd5:    p = 4'h5;
            3'd6:    p = 4'h1;
            default: p = 4'h9;
        endcase
        return p;
    endfunction

endpackage

// File: src/dual_stepper_sequencer_unit.sv
// ----------------------------------------------------------------------------
// dual_stepper_sequencer_unit: two-channel stepper motor sequencer
// Command-driven full, wave and half step coil sequencing with timer pacing.
// ----------------------------------------------------------------------------
// Takes one command item per clock while in_stall is low and returns exactly
// one result item per command, in order. Sustained rate is one item per cycle
// while neither in_stall nor out_stall stalls; an accepted item is held in
// the command queue, then in the execution stage that registers the result.
// A write to step_rate with a value from 1 to 20000 runs the serial divider;
// during that time cfg_ready and in_stall hold off further writes and items.
// A step_rate write above 20000 is ignored; other configuration writes take
// effect at once. Result fields coils_* and enable_* always show both
// channels; remaining, is_stepping and current_direction show the channel
// named by the command.
// ----------------------------------------------------------------------------
module dual_stepper_sequencer_unit
    import dss_pkg::*;
#(
    parameter int unsigned BUS_CLOCK_HZ = 40000000
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [RATE_W-1:0] cfg_data
);

    logic      rate_busy;
    logic      q_valid;
    logic      q_pop;
    cmd_t      q_cmd;
    cfg_wr_t   cfg_wr;
    rate_upd_t rate_upd;

    // Hold configuration off while a period derivation is in flight
    assign cfg_ready    = !rate_busy;
    assign cfg_wr.valid = cfg_valid && cfg_ready;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    // Front: accept and classify items, queue them for execution
    dss_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .hold     (rate_busy),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    // Rate unit: derive timer period and repeat limit from step_rate
    dss_rate #(
        .BUS_CLOCK_HZ (BUS_CLOCK_HZ)
    ) u_rate
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_wr),
        .busy  (rate_busy),
        .upd   (rate_upd)
    );

    // Back: execute commands on the channel state, drive the result register
    dss_back #(
        .BUS_CLOCK_HZ (BUS_CLOCK_HZ)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .cfg       (cfg_wr),
        .rate_upd  (rate_upd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // A busy divider must keep items out
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_ready |-> in_stall)
        else $error("item intake open while rate derivation busy");

    // An accepted item is in the queue on the next cycle
    a_item_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> q_valid)
        else $error("accepted item missing from command queue");

    // A result that reports stepping has at least one channel drive enabled
    a_step_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.is_stepping) |->
            (out_data.enable_first || out_data.enable_second))
        else $error("stepping channel reported with no drive enabled");

endmodule

// File: src/dss_front.sv
// ----------------------------------------------------------------------------
// dss_front: command intake and queue
// Accepts items, classifies them into commands and holds them in a short queue.
// ----------------------------------------------------------------------------
module dss_front
    import dss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    input  logic     hold,
    output logic     q_valid,
    output cmd_t     q_cmd,
    input  logic     q_pop
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    cmd_t              cmd_in;

    assign in_stall = hold || (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = entry_reg[rd_ptr_reg];

    // Classify the incoming item
    always_comb
    begin
        cmd_in.op         = in_data.op;
        cmd_in.channel    = in_data.channel;
        cmd_in.dir        = in_data.move_direction;
        cmd_in.steps      = unsigned'(in_data.step_total);
        cmd_in.steps_zero = (in_data.step_total == '0);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, q_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// File: src/dss_rate.sv
// ----------------------------------------------------------------------------
// dss_rate: step rate to timer period and repeat limit
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dss_rate
    import dss_pkg::*;
#(
    parameter int unsigned BUS_CLOCK_HZ = 40000000
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_wr_t   cfg,
    output logic      busy,
    output rate_upd_t upd
);

    localparam int unsigned BaseVal = BUS_CLOCK_HZ / PRESCALE - 1;
    localparam int unsigned KhzQ    = BaseVal / ONE_KHZ;
    localparam logic [PERIOD_W-1:0] KhzPeriod =
        (KhzQ > PERIOD_MAX) ? PERIOD_W'(PERIOD_MAX) : PERIOD_W'(KhzQ);
    localparam int unsigned DivW    = $clog2(BaseVal + 1);
    localparam int unsigned CntW    = $clog2(DivW + 1);

    div_state_t        state_reg;
    div_state_t        state_next;
    logic [CntW-1:0]   cnt_reg;
    logic [CntW-1:0]   cnt_next;
    logic [DivW-1:0]   qd_reg;
    logic [DivW-1:0]   qd_next;
    logic [RATE_W-1:0] rem_reg;
    logic [RATE_W-1:0] rem_next;
    logic [RATE_W-1:0] div_reg;
    logic [RATE_W-1:0] div_next;
    logic              big_reg;
    logic              big_next;
    logic              low_reg;
    logic              low_next;
    logic [RATE_W:0]   trial;
    logic [RATE_W:0]   diff;
    logic              fits;
    logic              rate_wr;

    assign busy    = (state_reg != DIV_IDLE);
    assign rate_wr = cfg.valid && (cfg.index == CFG_STEP_RATE);
    assign trial   = {rem_reg, qd_reg[DivW-1]};
    assign fits    = (trial >= {1'b0, div_reg});
    assign diff    = trial - {1'b0, div_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        qd_next    = qd_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        big_next   = big_reg;
        low_next   = low_reg;
        upd        = '0;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (rate_wr && (cfg.data == '0))
                begin
                    // Half a step per second: count off many 1 kHz ticks
                    upd.valid  = 1'b1;
                    upd.limit  = LIMIT_W'(ZERO_RATE_REPS);
                    upd.period = KhzPeriod;
                end
                else if (rate_wr && (cfg.data <= RATE_W'(RATE_MAX)))
                begin
                    div_next   = cfg.data;
                    big_next   = (cfg.data > RATE_W'(RATE_MED));
                    low_next   = (cfg.data <= RATE_W'(RATE_LOW));
                    qd_next    = (cfg.data > RATE_W'(RATE_MED)) ? DivW'(BaseVal)
                                                                : DivW'(ONE_KHZ - 1);
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = DIV_SHIFT;
                end
            end
            DIV_SHIFT:
            begin
                rem_next = fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
                qd_next  = {qd_reg[DivW-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(DivW - 1))
                begin
                    state_next = DIV_FINISH;
                end
            end
            DIV_FINISH:
            begin
                upd.valid = 1'b1;
                if (big_reg)
                begin
                    upd.limit  = '0;
                    upd.period = (qd_reg > DivW'(PERIOD_MAX)) ? PERIOD_W'(PERIOD_MAX)
                                                              : qd_reg[PERIOD_W-1:0];
                end
                else
                begin
                    upd.limit  = low_reg ? qd_reg[LIMIT_W-1:0] + 1'b1 : qd_reg[LIMIT_W-1:0];
                    upd.period = KhzPeriod;
                end
                state_next = DIV_IDLE;
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qd_reg  <= qd_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        big_reg <= big_next;
        low_reg <= low_next;
    end

endmodule

// File: src/dss_back.sv
// ----------------------------------------------------------------------------
// dss_back: command execution
// Applies queued commands to both channels and registers the result item.
// ----------------------------------------------------------------------------
module dss_back
    import dss_pkg::*;
#(
    parameter int unsigned BUS_CLOCK_HZ = 40000000
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  cmd_t      q_cmd,
    output logic      q_pop,
    input  cfg_wr_t   cfg,
    input  rate_upd_t rate_upd,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int unsigned BaseVal = BUS_CLOCK_HZ / PRESCALE - 1;
    localparam int unsigned InitQ   = BaseVal / RATE_DEFAULT;
    localparam logic [PERIOD_W-1:0] InitPeriod =
        (InitQ > PERIOD_MAX) ? PERIOD_W'(PERIOD_MAX) : PERIOD_W'(InitQ);
    // Default rate lies above the medium band, so no repeat ticks
    localparam logic [LIMIT_W-1:0]  InitLimit  = '0;

    chan_t               chan_reg  [2];
    chan_t               chan_next [2];
    logic [LIMIT_W-1:0]  rc_reg;
    logic [LIMIT_W-1:0]  rc_next;
    logic [LIMIT_W-1:0]  rc_inc;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [LIMIT_W-1:0]  limit_next;
    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] period_next;
    logic                timer_reg;
    logic                timer_next;
    logic [1:0]          mode_reg;
    logic [1:0]          mode_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    out_item_t           out_data_reg;
    out_item_t           out_data_next;
    chan_t               sel;
    chan_t               sel_new;
    chan_t               addr;
    logic                status;

    function automatic chan_t step_chan(input chan_t c, input logic [1:0] mode);
        chan_t              r;
        logic [COUNT_W-1:0] dec;
        r   = c;
        dec = (c.count == COUNT_MIN) ? c.count : c.count - 1'b1;
        case (c.st)
            RUN_OFF:
            begin
                r.en = 1'b0;
            end
            RUN_STEPPING:
            begin
                r.count = dec;
                if ((dec == '0) || dec[COUNT_W-1])
                begin
                    r.st = RUN_HALTED;
                end
                r.en = 1'b1;
                if (mode == MODE_HALF)
                begin
                    r.pins  = half_pattern(c.phase);
                    r.phase = c.dir ? c.phase - 1'b1 : c.phase + 1'b1;
                end
                else
                begin
                    r.pins  = (mode == MODE_WAVE) ? wave_pattern(c.phase[1:0])
                                                  : full_pattern(c.phase[1:0]);
                    r.phase = {1'b0, (c.dir ? c.phase[1:0] - 1'b1 : c.phase[1:0] + 1'b1)};
                end
            end
            default:
            begin
                if (c.count[COUNT_W-1])
                begin
                    r.count = '0;
                end
            end
        endcase
        return r;
    endfunction

    assign q_pop     = q_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign sel       = q_cmd.channel ? chan_reg[1] : chan_reg[0];
    assign rc_inc    = rc_reg + 1'b1;

    always_comb
    begin
        chan_next[0] = chan_reg[0];
        chan_next[1] = chan_reg[1];
        rc_next      = rc_reg;
        limit_next   = limit_reg;
        period_next  = period_reg;
        timer_next   = timer_reg;
        mode_next    = mode_reg;
        status       = 1'b0;
        sel_new      = sel;

        if (q_pop)
        begin
            unique case (q_cmd.op)
                OP_TICK:
                begin
                    if (timer_reg)
                    begin
                        if (rc_inc > limit_reg)
                        begin
                            rc_next      = '0;
                            chan_next[0] = step_chan(chan_reg[0], mode_reg);
                            chan_next[1] = step_chan(chan_reg[1], mode_reg);
                            if ((chan_reg[0].st == RUN_OFF) || (chan_reg[1].st == RUN_OFF))
                            begin
                                timer_next = 1'b0;
                            end
                        end
                        else
                        begin
                            rc_next = rc_inc;
                        end
                    end
                end
                OP_INIT:
                begin
                    if (chan_reg[0].st != RUN_OFF)
                    begin
                        status = 1'b1;
                    end
                    else
                    begin
                        chan_next[0].count = '0;
                        chan_next[0].pins  = PINS_IDLE;
                        chan_next[0].st    = RUN_INITED;
                        limit_next         = InitLimit;
                        period_next        = InitPeriod;
                        if (chan_reg[1].st != RUN_OFF)
                        begin
                            status = 1'b1;
                        end
                        else
                        begin
                            chan_next[1].count = '0;
                            chan_next[1].pins  = PINS_IDLE;
                            chan_next[1].st    = RUN_INITED;
                            timer_next         = 1'b1;
                        end
                    end
                end
                OP_SET_STEPS:
                begin
                    if (sel.st == RUN_OFF)
                    begin
                        status = 1'b1;
                    end
                    else
                    begin
                        sel_new.dir   = q_cmd.dir;
                        sel_new.count = q_cmd.steps;
                    end
                end
                OP_START:
                begin
                    if ((sel.count == '0) || (sel.st == RUN_STEPPING))
                    begin
                        status = 1'b1;
                    end
                    else
                    begin
                        sel_new.st = RUN_STEPPING;
                        sel_new.en = 1'b1;
                    end
                end
                OP_SET_START:
                begin
                    if ((sel.st == RUN_OFF) || q_cmd.steps_zero)
                    begin
                        status = 1'b1;
                    end
                    else
                    begin
                        sel_new.dir   = q_cmd.dir;
                        sel_new.count = q_cmd.steps;
                        // Steps stay set even when the start is refused
                        if (sel.st == RUN_STEPPING)
                        begin
                            status = 1'b1;
                        end
                        else
                        begin
                            sel_new.st = RUN_STEPPING;
                            sel_new.en = 1'b1;
                        end
                    end
                end
                OP_STOP:
                begin
                    if ((sel.st == RUN_OFF) || (sel.st == RUN_HALTED))
                    begin
                        status = 1'b1;
                    end
                    else
                    begin
                        sel_new.st = RUN_HALTED;
                    end
                end
                OP_END:
                begin
                    if ((chan_reg[0].st == RUN_OFF) || (chan_reg[1].st == RUN_OFF))
                    begin
                        status = 1'b1;
                    end
                    else
                    begin
                        timer_next = 1'b0;
                        limit_next = '0;
                        for (int i = 0; i < 2; i++)
                        begin
                            chan_next[i].st    = RUN_OFF;
                            chan_next[i].en    = 1'b0;
                            chan_next[i].count = '0;
                            chan_next[i].phase = '0;
                        end
                    end
                end
                OP_QUERY:
                begin
                    status = 1'b0;
                end
                default:
                begin
                    status = 1'b0;
                end
            endcase

            // Write back the addressed channel for per-channel commands
            if ((q_cmd.op == OP_SET_STEPS) || (q_cmd.op == OP_START) ||
                (q_cmd.op == OP_SET_START) || (q_cmd.op == OP_STOP))
            begin
                if (q_cmd.channel)
                begin
                    chan_next[1] = sel_new;
                end
                else
                begin
                    chan_next[0] = sel_new;
                end
            end
        end

        if (cfg.valid && (cfg.index == CFG_DRIVE_MODE))
        begin
            mode_next = cfg.data[1:0];
        end
        if (rate_upd.valid)
        begin
            limit_next  = rate_upd.limit;
            period_next = rate_upd.period;
        end
    end

    // Result item from the state after the command
    always_comb
    begin
        addr                            = q_cmd.channel ? chan_next[1] : chan_next[0];
        out_data_next.status            = status;
        out_data_next.coils_first       = chan_next[0].pins;
        out_data_next.enable_first      = chan_next[0].en;
        out_data_next.coils_second      = chan_next[1].pins;
        out_data_next.enable_second     = chan_next[1].en;
        out_data_next.remaining         = signed'(addr.count);
        out_data_next.is_stepping       = (addr.st == RUN_STEPPING);
        out_data_next.current_direction = addr.dir;
        out_data_next.timer_period      = period_next;
        out_data_next.timer_on          = timer_next;

        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                chan_reg[i].st    <= RUN_OFF;
                chan_reg[i].phase <= '0;
                chan_reg[i].dir   <= 1'b0;
                chan_reg[i].count <= '0;
                chan_reg[i].pins  <= PINS_IDLE;
                chan_reg[i].en    <= 1'b0;
            end
            rc_reg        <= '0;
            limit_reg     <= InitLimit;
            period_reg    <= InitPeriod;
            timer_reg     <= 1'b0;
            mode_reg      <= MODE_FULL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            chan_reg[0]   <= chan_next[0];
            chan_reg[1]   <= chan_next[1];
            rc_reg        <= rc_next;
            limit_reg     <= limit_next;
            period_reg    <= period_next;
            timer_reg     <= timer_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
